@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: never");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/pcqf_pkg.sv @@
// Types, codes and microcode ROM for the panel command queue framer.
// No dependencies.
package pcqf_pkg;

  // Input opcodes
  localparam logic [2:0] OP_DIAL   = 3'd0;
  localparam logic [2:0] OP_LEVEL  = 3'd1;
  localparam logic [2:0] OP_BUTTON = 3'd2;
  localparam logic [2:0] OP_SEND   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;
  localparam logic [1:0] KIND_IDLE = 2'd3;

  localparam logic [15:0] GAP_RESET = 16'd100;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  // Microcode program counter and section entry points
  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] ADDR_START  = 6'd0;
  localparam logic [PC_W-1:0] ADDR_DIAL   = 6'd3;
  localparam logic [PC_W-1:0] ADDR_LEVEL  = 6'd12;
  localparam logic [PC_W-1:0] ADDR_BUTTON = 6'd27;

  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  typedef enum logic [1:0] {
    QSEL_DIAL   = 2'd0,
    QSEL_LEVEL  = 2'd1,
    QSEL_BUTTON = 2'd2
  } qsel_e;

  // Byte source of one microcode step
  typedef enum logic [1:0] {
    SRC_CONST  = 2'd0,
    SRC_DIAL_A = 2'd1,
    SRC_DIAL_B = 2'd2,
    SRC_NIBBLE = 2'd3
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] chr;
    logic [2:0] nib;
    logic       dispatch;  // jump to the section of the selected queue
    logic       last;      // final byte of the frame
  } ctrl_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [2:0] nonempty;
    logic [2:0] full;
  } qstat_t;

  // Sequencer status and current control word
  typedef struct packed {
    logic  busy;
    qsel_e sel;
    ctrl_t cw;
  } seq_t;

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n < 4'd10) ? w + 8'd48 : w + 8'd55;
  endfunction

  // Microcode ROM
  function automatic ctrl_t ucode_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{src: SRC_CONST, chr: 8'h00, nib: 3'd0, dispatch: 1'b0, last: 1'b0};
    unique case (pc)
      // common prefix
      6'd0:  w.chr = "S";
      6'd1:  w.chr = "W";
      6'd2:  begin w.chr = "D"; w.dispatch = 1'b1; end
      // dial frame
      6'd3:  w.chr = "R";
      6'd4:  w.src = SRC_DIAL_A;
      6'd5:  w.src = SRC_DIAL_B;
      6'd6:  w.chr = "0";
      6'd7:  w.chr = "1";
      6'd8:  w.chr = "0";
      6'd9:  w.chr = "0";
      6'd10: w.chr = CHR_CR;
      6'd11: begin w.chr = CHR_LF; w.last = 1'b1; end
      // level frame
      6'd12: w.chr = "V";
      6'd13: begin w.src = SRC_NIBBLE; w.nib = 3'd7; end
      6'd14: begin w.src = SRC_NIBBLE; w.nib = 3'd6; end
      6'd15: begin w.src = SRC_NIBBLE; w.nib = 3'd5; end
      6'd16: begin w.src = SRC_NIBBLE; w.nib = 3'd4; end
      6'd17: begin w.src = SRC_NIBBLE; w.nib = 3'd3; end
      6'd18: begin w.src = SRC_NIBBLE; w.nib = 3'd2; end
      6'd19: begin w.src = SRC_NIBBLE; w.nib = 3'd1; end
      6'd20: begin w.src = SRC_NIBBLE; w.nib = 3'd0; end
      6'd21: w.chr = "0";
      6'd22: w.chr = "1";
      6'd23: w.chr = "0";
      6'd24: w.chr = "0";
      6'd25: w.chr = CHR_CR;
      6'd26: begin w.chr = CHR_LF; w.last = 1'b1; end
      // button frame
      6'd27: w.chr = "S";
      6'd28: begin w.src = SRC_NIBBLE; w.nib = 3'd6; end
      6'd29: begin w.src = SRC_NIBBLE; w.nib = 3'd5; end
      6'd30: begin w.src = SRC_NIBBLE; w.nib = 3'd4; end
      6'd31: begin w.src = SRC_NIBBLE; w.nib = 3'd3; end
      6'd32: begin w.src = SRC_NIBBLE; w.nib = 3'd2; end
      6'd33: begin w.src = SRC_NIBBLE; w.nib = 3'd1; end
      6'd34: begin w.src = SRC_NIBBLE; w.nib = 3'd0; end
      6'd35: w.chr = "0";
      6'd36: w.chr = "0";
      6'd37: w.chr = "1";
      6'd38: w.chr = "0";
      6'd39: w.chr = "0";
      6'd40: w.chr = CHR_CR;
      6'd41: begin w.chr = CHR_LF; w.last = 1'b1; end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/pcqf_queues.sv @@
// Three ring queues (dial, levels, buttons) with their storage.
// Depends on pcqf_pkg.
module pcqf_queues #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  pcqf_pkg::qsel_e      sel_i,
  input  logic [7:0]           dial_char_i,
  input  logic [31:0]          level_word_i,
  input  logic [4:0]           button_number_i,
  output pcqf_pkg::qstat_t     stat_o,
  output logic [7:0]           dial_rd_o,
  output logic [31:0]          level_rd_o,
  output logic [4:0]           button_rd_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] head_q [3];
  logic [PTR_W-1:0] tail_q [3];
  logic [CNT_W-1:0] cnt_q  [3];
  logic [2:0]       push_en;
  logic [2:0]       pop_en;
  logic [2:0]       full;

  logic [7:0]  dial_mem   [QUEUE_DEPTH];
  logic [31:0] level_mem  [QUEUE_DEPTH];
  logic [4:0]  button_mem [QUEUE_DEPTH];
  logic [7:0]  dial_rd_q;
  logic [31:0] level_rd_q;
  logic [4:0]  button_rd_q;

  // Per-queue strobes
  always_comb begin
    push_en = 3'b000;
    pop_en  = 3'b000;
    unique case (sel_i)
      pcqf_pkg::QSEL_DIAL: begin
        push_en[0] = push_i && !full[0];
        pop_en[0]  = pop_i;
      end
      pcqf_pkg::QSEL_LEVEL: begin
        push_en[1] = push_i && !full[1];
        pop_en[1]  = pop_i;
      end
      pcqf_pkg::QSEL_BUTTON: begin
        push_en[2] = push_i && !full[2];
        pop_en[2]  = pop_i;
      end
      default: ;
    endcase
  end

  // Status
  always_comb begin
    for (int q = 0; q < 3; q++) begin
      full[q]            = (cnt_q[q] == CNT_FULL);
      stat_o.full[q]     = full[q];
      stat_o.nonempty[q] = (cnt_q[q] != '0);
    end
  end

  // Pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < 3; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else begin
      for (int q = 0; q < 3; q++) begin
        if (push_en[q]) begin
          tail_q[q] <= (tail_q[q] == PTR_LAST) ? '0 : tail_q[q] + 1'b1;
          cnt_q[q]  <= cnt_q[q] + 1'b1;
        end else if (pop_en[q]) begin
          head_q[q] <= (head_q[q] == PTR_LAST) ? '0 : head_q[q] + 1'b1;
          cnt_q[q]  <= cnt_q[q] - 1'b1;
        end
      end
    end
  end

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (push_en[0]) dial_mem[tail_q[0]]   <= dial_char_i;
    if (push_en[1]) level_mem[tail_q[1]]  <= level_word_i;
    if (push_en[2]) button_mem[tail_q[2]] <= button_number_i;
    if (pop_en[0])  dial_rd_q   <= dial_mem[head_q[0]];
    if (pop_en[1])  level_rd_q  <= level_mem[head_q[1]];
    if (pop_en[2])  button_rd_q <= button_mem[head_q[2]];
  end

  assign dial_rd_o   = dial_rd_q;
  assign level_rd_o  = level_rd_q;
  assign button_rd_o = button_rd_q;

endmodule

@@ rtl/pcqf_sequencer.sv @@
// Microcode sequencer: step counter, ROM fetch and section dispatch.
// Depends on pcqf_pkg.
module pcqf_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             launch_i,
  input  pcqf_pkg::qsel_e  sel_i,
  output pcqf_pkg::seq_t   seq_o
);

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } seq_state_e;

  seq_state_e                    state_q;
  logic [pcqf_pkg::PC_W-1:0]     pc_q;
  pcqf_pkg::qsel_e               sel_q;
  pcqf_pkg::ctrl_t               cw;
  logic [pcqf_pkg::PC_W-1:0]     target;

  // Fetch
  always_comb cw = pcqf_pkg::ucode_word(pc_q);

  // Section entry for the selected queue
  always_comb begin
    unique case (sel_q)
      pcqf_pkg::QSEL_DIAL:   target = pcqf_pkg::ADDR_DIAL;
      pcqf_pkg::QSEL_LEVEL:  target = pcqf_pkg::ADDR_LEVEL;
      pcqf_pkg::QSEL_BUTTON: target = pcqf_pkg::ADDR_BUTTON;
      default:               target = pcqf_pkg::ADDR_START;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      pc_q    <= pcqf_pkg::ADDR_START;
      sel_q   <= pcqf_pkg::QSEL_DIAL;
    end else begin
      unique case (state_q)
        SQ_IDLE: begin
          if (launch_i) begin
            state_q <= SQ_RUN;
            pc_q    <= pcqf_pkg::ADDR_START;
            sel_q   <= sel_i;
          end
        end
        SQ_RUN: begin
          if (cw.last) begin
            state_q <= SQ_IDLE;
          end else if (cw.dispatch) begin
            pc_q <= target;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign seq_o.busy = (state_q == SQ_RUN);
  assign seq_o.sel  = sel_q;
  assign seq_o.cw   = cw;

endmodule

@@ rtl/panel_command_queue_framer.sv @@
// Panel command queue framer: enqueue, tick and send decode, byte datapath.
// Enqueues and ticks are taken whenever not busy; an enqueue or idle send answers the next cycle.
// A send streams 12 or 18 bytes one per cycle, the first passing through the sequencer state
// and the result register; busy stays high for one microcode word per byte.
// Async active-low reset empties the queues, zeroes the tick count and sets the gap
// to 100; queue storage is not cleared. Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module panel_command_queue_framer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic signed [7:0] dial_char_i,
  input  logic [7:0]  level_it_i,
  input  logic [7:0]  level_if_i,
  input  logic [7:0]  squelch_level_i,
  input  logic [7:0]  volume_level_i,
  input  logic [4:0]  button_number_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  pcqf_pkg::qstat_t qstat;
  pcqf_pkg::seq_t   seq;
  pcqf_pkg::qsel_e  sel;
  pcqf_pkg::qsel_e  q_sel;

  logic        accept;
  logic        is_enq;
  logic        is_send;
  logic        ready;
  logic        btn_ok;
  logic        enq_full;
  logic [7:0]  dial_rd;
  logic [31:0] level_rd;
  logic [4:0]  button_rd;
  logic [31:0] word;
  logic [3:0]  nibble;
  logic [7:0]  dial_a;
  logic [7:0]  dial_b;
  logic [7:0]  byte_val;

  logic [15:0] gap_q;
  logic [15:0] ticks_q, ticks_d;
  logic        strobe_q, strobe_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;

  assign accept  = start && !seq.busy;
  assign is_send = (opcode_i == pcqf_pkg::OP_SEND);
  assign btn_ok  = qstat.nonempty[2] && (ticks_q > gap_q);

  // Enqueue decode and send priority
  always_comb begin
    is_enq = 1'b1;
    q_sel  = pcqf_pkg::QSEL_DIAL;
    case (opcode_i)
      pcqf_pkg::OP_DIAL:   q_sel = pcqf_pkg::QSEL_DIAL;
      pcqf_pkg::OP_LEVEL:  q_sel = pcqf_pkg::QSEL_LEVEL;
      pcqf_pkg::OP_BUTTON: q_sel = pcqf_pkg::QSEL_BUTTON;
      default:             is_enq = 1'b0;
    endcase
    ready = 1'b1;
    if (qstat.nonempty[0]) begin
      sel = pcqf_pkg::QSEL_DIAL;
    end else if (qstat.nonempty[1]) begin
      sel = pcqf_pkg::QSEL_LEVEL;
    end else begin
      sel   = pcqf_pkg::QSEL_BUTTON;
      ready = btn_ok;
    end
    enq_full = qstat.full[q_sel];
  end

  pcqf_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept && is_enq),
    .pop_i           (accept && is_send && ready),
    .sel_i           (is_send ? sel : q_sel),
    .dial_char_i     (dial_char_i),
    .level_word_i    ({level_it_i, level_if_i, squelch_level_i, volume_level_i}),
    .button_number_i (button_number_i),
    .stat_o          (qstat),
    .dial_rd_o       (dial_rd),
    .level_rd_o      (level_rd),
    .button_rd_o     (button_rd)
  );

  pcqf_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (accept && is_send && ready),
    .sel_i    (sel),
    .seq_o    (seq)
  );

  // Dial step characters
  always_comb begin
    dial_a = "8";
    dial_b = "0";
    if (!dial_rd[7] && dial_rd >= "A") begin
      dial_a = "7";
      dial_b = dial_rd;
    end else if (!dial_rd[7] && dial_rd > "0") begin
      dial_b = dial_rd;
    end
  end

  // Hex digit source: level word or button bit mask
  always_comb begin
    if (seq.sel == pcqf_pkg::QSEL_LEVEL) begin
      word = level_rd;
    end else begin
      word = (button_rd == 5'd0) ? 32'd0 : (32'd1 << button_rd);
    end
    nibble = word[{seq.cw.nib, 2'b00} +: 4];
  end

  // Byte select from the control word
  always_comb begin
    case (seq.cw.src)
      pcqf_pkg::SRC_DIAL_A: byte_val = dial_a;
      pcqf_pkg::SRC_DIAL_B: byte_val = dial_b;
      pcqf_pkg::SRC_NIBBLE: byte_val = pcqf_pkg::hex_digit(nibble);
      default:              byte_val = seq.cw.chr;
    endcase
  end

  // Result register and tick counter next state
  always_comb begin
    strobe_d = 1'b0;
    kind_d   = pcqf_pkg::KIND_BYTE;
    byte_d   = 8'd0;
    last_d   = 1'b0;
    ticks_d  = ticks_q;
    if (seq.busy) begin
      strobe_d = 1'b1;
      byte_d   = byte_val;
      last_d   = seq.cw.last;
    end else if (accept) begin
      if (is_enq) begin
        strobe_d = 1'b1;
        kind_d   = enq_full ? pcqf_pkg::KIND_FULL : pcqf_pkg::KIND_ACK;
        last_d   = 1'b1;
      end else if (is_send) begin
        if (!ready) begin
          strobe_d = 1'b1;
          kind_d   = pcqf_pkg::KIND_IDLE;
          last_d   = 1'b1;
        end else if (sel == pcqf_pkg::QSEL_BUTTON) begin
          ticks_d = 16'd0;
        end
      end else if (opcode_i == pcqf_pkg::OP_TICK && ticks_q != pcqf_pkg::TICK_MAX) begin
        ticks_d = ticks_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= pcqf_pkg::GAP_RESET;
      ticks_q  <= 16'd0;
      strobe_q <= 1'b0;
      kind_q   <= pcqf_pkg::KIND_BYTE;
      byte_q   <= 8'd0;
      last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) gap_q <= cfg_wdata_i;
      ticks_q  <= ticks_d;
      strobe_q <= strobe_d;
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
    end
  end

  assign busy       = seq.busy;
  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  // Checks
  `ASSERT_NEXT(a_busy_streams, clk_i, rst_ni, busy, strobe_o && kind_o == pcqf_pkg::KIND_BYTE)
  `ASSERT_IMPLIES(a_last_frees, clk_i, rst_ni, strobe_o && last_o && kind_o == pcqf_pkg::KIND_BYTE, !busy)
  `ASSERT_NEXT(a_tick_silent, clk_i, rst_ni, start && !busy && opcode_i == pcqf_pkg::OP_TICK, !strobe_o)
  `ASSERT_NEVER(a_status_last, clk_i, rst_ni, strobe_o && kind_o != pcqf_pkg::KIND_BYTE && !last_o)

endmodule
